@@ hw/rtl/wnpe_pkg.sv @@
// Shared types and constants for the weather nibble packet encoder.
`timescale 1ns / 1ps

package wnpe_pkg;

    localparam int PACKET_NIBBLES = 13;
    localparam int IDX_W          = $clog2(PACKET_NIBBLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_NIBBLES - 1);

    // Fixed packet nibbles.
    localparam logic [3:0] PREAMBLE_HI = 4'h0;
    localparam logic [3:0] PREAMBLE_LO = 4'h9;
    localparam logic [3:0] HUMID_D0    = 4'hD;

    // Bit x is set when x has an even number of ones.
    localparam logic [15:0] PARITY_LUT = 16'h9669;

    localparam logic [9:0] TEMP_MAX = 10'd999;

    // floor(u / 100) == (u * RECIP_100) >> RECIP_SHIFT for every 12-bit u.
    localparam logic [10:0] RECIP_100   = 11'd1311;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [6:0]  HUNDRED     = 7'd100;

    // Register reset values.
    localparam logic [7:0] SENSOR_ID_RST   = 8'd34;
    localparam logic [3:0] GROUP_FLAGS_RST = 4'd7;
    localparam logic [3:0] INTERVAL_RST    = 4'd8;
    localparam logic [9:0] TEMP_OFFSET_RST = 10'd300;

    typedef enum logic [1:0] {
        ACT_TEMP  = 2'd0,
        ACT_HUMID = 2'd1,
        ACT_RAIN  = 2'd2,
        ACT_WIND  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_SENSOR_ID   = 2'd0,
        CFG_GROUP_FLAGS = 2'd1,
        CFG_INTERVAL    = 2'd2,
        CFG_TEMP_OFFSET = 2'd3
    } t_cfg_reg;

    // Two BCD digits {tens, ones} of a remainder below one hundred.
    typedef logic [7:0] t_bcd_lut [0:127];

    function automatic t_bcd_lut f_bcd_lut();
        t_bcd_lut lut;
        for (int i = 0; i < 128; i++) begin
            lut[i] = {4'(((i % 100) / 10)), 4'(i % 10)};
        end
        return lut;
    endfunction

    localparam t_bcd_lut BCD_LUT = f_bcd_lut();

endpackage

@@ hw/rtl/weather_nibble_packet_encoder_unit.sv @@
// Weather nibble packet encoder: measurement in, 13-nibble sensor packet out.
// A packet's first nibble is offered after its word passes every pipeline register.
// The output port sends one nibble per cycle while m_axis_tready is high;
// packets follow each other with no gap while the sink keeps m_axis_tready high.
// Input, clamp, reciprocal-multiply and packet-build registers buffer later words.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps

module weather_nibble_packet_encoder_unit
    import wnpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [12:0] value (signed), [16:13] direction, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] nibble, rest zero
    output logic        m_axis_tlast,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    // Configuration registers.
    logic [7:0] r_sensor_id;
    logic [3:0] r_group_flags;
    logic [3:0] r_interval;
    logic [9:0] r_temp_offset;

    // Input stage.
    logic               r_in_vld;
    t_action            r_in_act;
    logic signed [12:0] r_in_value;
    logic [3:0]         r_in_dir;

    // Clamp stage.
    logic        r_u_vld;
    t_action     r_u_act;
    logic [11:0] r_u;
    logic [3:0]  r_u_dir;

    // Quotient stage.
    logic        r_q_vld;
    t_action     r_q_act;
    logic [11:0] r_q_u;
    logic [3:0]  r_q_dir;
    logic [5:0]  r_q;

    // Packet stage.
    logic             r_pk_vld;
    logic [3:0]       r_pk [PACKET_NIBBLES];
    logic [IDX_W-1:0] r_idx;

    logic adv_u, adv_q, adv_p, out_done;

    logic signed [13:0] temp_sum;
    logic [11:0]        n_u;
    logic [22:0]        recip_prod;
    logic [5:0]         n_q;
    logic [12:0]        hund_prod;
    logic [12:0]        rem_diff;
    logic [7:0]         bcd;
    logic [3:0]         d2, d1, d0;
    logic [3:0]         n_pk [PACKET_NIBBLES];
    logic [3:0]         sum_a, sum_b, sum_c;

    assign out_done = r_pk_vld && m_axis_tready && (r_idx == IDX_LAST);
    assign adv_p    = r_q_vld && (!r_pk_vld || out_done);
    assign adv_q    = r_u_vld && (!r_q_vld || adv_p);
    assign adv_u    = r_in_vld && (!r_u_vld || adv_q);

    assign s_axis_tready = !r_in_vld || adv_u;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_pk_vld;
    assign m_axis_tdata  = {4'b0000, r_pk[r_idx]};
    assign m_axis_tlast  = (r_idx == IDX_LAST);

    // Clamp stage: temperature saturates to 0..999 after the offset,
    // humidity clamps negative values to zero, rain and wind keep raw low bits.
    always_comb begin
        temp_sum = 14'(r_in_value) + $signed({4'b0000, r_temp_offset});
        unique case (r_in_act)
            ACT_TEMP: begin
                if (temp_sum < 0) begin
                    n_u = '0;
                end else if (temp_sum > $signed({4'b0000, TEMP_MAX})) begin
                    n_u = {2'b00, TEMP_MAX};
                end else begin
                    n_u = temp_sum[11:0];
                end
            end
            ACT_HUMID: begin
                n_u = r_in_value[12] ? 12'd0 : r_in_value[11:0];
            end
            ACT_RAIN, ACT_WIND: begin
                n_u = r_in_value[11:0];
            end
            default: n_u = r_in_value[11:0];
        endcase
    end

    assign recip_prod = 23'(r_u) * 23'(RECIP_100);
    assign n_q        = recip_prod[RECIP_SHIFT +: 6];

    // Packet stage: for temperature and humidity the remainder by one hundred goes through the BCD table.
    always_comb begin
        hund_prod = 13'(r_q) * 13'(HUNDRED);
        rem_diff  = {1'b0, r_q_u} - hund_prod;
        bcd       = BCD_LUT[rem_diff[6:0]];
        unique case (r_q_act)
            ACT_TEMP: begin
                d2 = r_q[3:0];
                d1 = bcd[7:4];
                d0 = bcd[3:0];
            end
            ACT_HUMID: begin
                d2 = bcd[7:4];
                d1 = bcd[3:0];
                d0 = HUMID_D0;
            end
            ACT_RAIN: begin
                d2 = r_q_u[11:8];
                d1 = r_q_u[7:4];
                d0 = r_q_u[3:0];
            end
            ACT_WIND: begin
                d2 = r_q_u[7:4];
                d1 = r_q_u[3:0];
                d0 = r_q_dir;
            end
            default: begin
                d2 = r_q_u[11:8];
                d1 = r_q_u[7:4];
                d0 = r_q_u[3:0];
            end
        endcase

        n_pk[0]  = PREAMBLE_HI;
        n_pk[1]  = PREAMBLE_LO;
        n_pk[2]  = {1'b0, PARITY_LUT[d2 ^ d1 ^ d0], r_q_act};
        n_pk[3]  = r_sensor_id[7:4];
        n_pk[4]  = r_sensor_id[3:0];
        n_pk[5]  = r_group_flags;
        n_pk[6]  = r_interval;
        n_pk[7]  = d2;
        n_pk[8]  = d1;
        n_pk[9]  = d0;
        n_pk[10] = ~d2;
        n_pk[11] = ~d1;

        sum_a    = n_pk[0] + n_pk[1] + n_pk[2] + n_pk[3];
        sum_b    = n_pk[4] + n_pk[5] + n_pk[6] + n_pk[7];
        sum_c    = n_pk[8] + n_pk[9] + n_pk[10] + n_pk[11];
        n_pk[12] = sum_a + sum_b + sum_c;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_u_vld       <= 1'b0;
            r_q_vld       <= 1'b0;
            r_pk_vld      <= 1'b0;
            r_idx         <= '0;
            r_sensor_id   <= SENSOR_ID_RST;
            r_group_flags <= GROUP_FLAGS_RST;
            r_interval    <= INTERVAL_RST;
            r_temp_offset <= TEMP_OFFSET_RST;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (!r_u_vld || adv_q) begin
                r_u_vld <= r_in_vld;
            end
            if (!r_q_vld || adv_p) begin
                r_q_vld <= r_u_vld;
            end
            if (!r_pk_vld || out_done) begin
                r_pk_vld <= r_q_vld;
            end
            if (r_pk_vld && m_axis_tready) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_SENSOR_ID:   r_sensor_id   <= i_cfg_data[7:0];
                    CFG_GROUP_FLAGS: r_group_flags <= i_cfg_data[3:0];
                    CFG_INTERVAL:    r_interval    <= i_cfg_data[3:0];
                    CFG_TEMP_OFFSET: r_temp_offset <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_act   <= t_action'(s_axis_tuser);
            r_in_value <= $signed(s_axis_tdata[12:0]);
            r_in_dir   <= s_axis_tdata[16:13];
        end
        if (adv_u) begin
            r_u_act <= r_in_act;
            r_u     <= n_u;
            r_u_dir <= r_in_dir;
        end
        if (adv_q) begin
            r_q_act <= r_u_act;
            r_q_u   <= r_u;
            r_q_dir <= r_u_dir;
            r_q     <= n_q;
        end
        if (adv_p) begin
            r_pk <= n_pk;
        end
    end

endmodule
